// ===== rtl/core/klt_pkg.sv =====
// ----------------------------------------------------------------------------
// klt_pkg
// shared constants, operation and status codes for the keyed lock table
// ----------------------------------------------------------------------------
package klt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int KEY_W         = 32;

    typedef enum logic [2:0] {
        MODE_CREATE  = 3'd0,
        MODE_LOOKUP  = 3'd1,
        MODE_DESTROY = 3'd2,
        MODE_LOCK    = 3'd3,
        MODE_UNLOCK  = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_NOT_FOUND = 3'd1,
        STAT_DUPLICATE = 3'd2,
        STAT_FULL      = 3'd3,
        STAT_RETRY     = 3'd4,
        STAT_INVALID   = 3'd5
    } status_t;

    // scan result kept by the match unit
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] found_idx;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
    } match_t;

endpackage

// ===== rtl/core/klt_key_ram.sv =====
// ----------------------------------------------------------------------------
// klt_key_ram
// key store, one write port and one registered read port
// ----------------------------------------------------------------------------
module klt_key_ram
    import klt_pkg::*;
(
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [KEY_W-1:0] wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [KEY_W-1:0] rd_data
);

    logic [KEY_W-1:0] mem [TABLE_ENTRIES];
    logic [KEY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/klt_match_unit.sv =====
// ----------------------------------------------------------------------------
// klt_match_unit
// shared key compare, records lowest matching and lowest free entry
// ----------------------------------------------------------------------------
module klt_match_unit
    import klt_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             clear,
    input  logic             cmp_valid,
    input  logic [IDX_W-1:0] cmp_idx,
    input  logic             cmp_used,
    input  logic [KEY_W-1:0] cmp_key,
    input  logic [KEY_W-1:0] req_key,
    output logic             hit_now,
    output match_t           match
);

    match_t match_reg;

    assign hit_now = cmp_valid && cmp_used && (cmp_key == req_key) && !match_reg.found;

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            match_reg.found      <= 1'b0;
            match_reg.free_found <= 1'b0;
        end else if (cmp_valid) begin
            if (hit_now) begin
                match_reg.found     <= 1'b1;
                match_reg.found_idx <= cmp_idx;
            end
            // first unused slot seen so far
            if (!cmp_used && !match_reg.free_found) begin
                match_reg.free_found <= 1'b1;
                match_reg.free_idx   <= cmp_idx;
            end
        end
    end

    assign match = match_reg;

endmodule

// ===== rtl/core/keyed_lock_table_top.sv =====
// ----------------------------------------------------------------------------
// keyed_lock_table_top
// table of named locks: create, lookup, destroy, lock and unlock by key
// ----------------------------------------------------------------------------
// usage:
//   one request is one transfer on the s_ channel, one answer is one transfer
//   on the m_ channel, in request order.
//   s_tuser carries the operation, s_tdata the key and the destroy handle.
//   m_tdata carries the handle created or found and a status code.
// timing:
//   create, lookup, lock and unlock walk the key store one entry a cycle
//   through a single compare unit; a walk stops at the first key hit.
//   a request whose key hits entry i ends its walk at entry i; a miss walks
//   all TABLE_ENTRIES entries. the exec state then forms the answer.
//   destroy and unknown operations need no walk and go straight to exec.
//   s_tready is high only while no request is in work, so a new request is
//   taken only once the previous one has left the exec state.
// reset:
//   aresetn clears all used and locked marks at once; no clearing pass.
// stall:
//   the answer sits in an output register; the next request is taken while
//   it waits, and a finished request holds until that register is free.
// ----------------------------------------------------------------------------
module keyed_lock_table_top
    import klt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // lock_key[31:0], entry_handle[35:32], zero pad
    input  logic [2:0]  s_tuser,    // mode[2:0]
    // answer channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata     // result_handle[3:0], status[6:4], zero pad
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC
    } state_t;

    state_t state_reg;

    // request held for the whole operation
    logic [2:0]       req_mode_reg;
    logic [KEY_W-1:0] req_key_reg;
    logic [3:0]       req_handle_reg;

    // per-entry marks in flip-flops
    logic [TABLE_ENTRIES-1:0] entry_used_reg;
    logic [TABLE_ENTRIES-1:0] entry_locked_reg;
    logic [TABLE_ENTRIES-1:0] entry_used_next;
    logic [TABLE_ENTRIES-1:0] entry_locked_next;

    // scan sequencer
    logic [CNT_W-1:0] cnt_reg;
    logic             cmp_valid_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             rd_en;
    logic             scan_last;

    // answer register
    logic             m_tvalid_reg;
    logic [3:0]       res_handle_reg;
    logic [2:0]       res_status_reg;
    logic [3:0]       res_handle_next;
    status_t          res_status_next;

    // key store and compare unit
    logic             key_we;
    logic [IDX_W-1:0] key_waddr;
    logic [KEY_W-1:0] key_rdata;
    logic             hit_now;
    logic             start;
    match_t           match;
    logic             out_free;
    logic [IDX_W-1:0] hnd_idx;

    assign s_tready = (state_reg == ST_IDLE);
    assign start    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // read one entry a cycle while walking
    assign rd_en     = (state_reg == ST_SCAN) && (cnt_reg != CNT_W'(TABLE_ENTRIES));
    assign scan_last = cmp_valid_reg && (cmp_idx_reg == IDX_W'(TABLE_ENTRIES - 1));

    klt_key_ram u_key_ram (
        .aclk    (aclk),
        .wr_en   (key_we),
        .wr_addr (key_waddr),
        .wr_data (req_key_reg),
        .rd_en   (rd_en),
        .rd_addr (cnt_reg[IDX_W-1:0]),
        .rd_data (key_rdata)
    );

    klt_match_unit u_match (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (start),
        .cmp_valid (cmp_valid_reg),
        .cmp_idx   (cmp_idx_reg),
        .cmp_used  (entry_used_reg[cmp_idx_reg]),
        .cmp_key   (key_rdata),
        .req_key   (req_key_reg),
        .hit_now   (hit_now),
        .match     (match)
    );

    assign hnd_idx = IDX_W'(req_handle_reg);

    // operation outcome, applied in the exec state once the answer register is free
    always_comb begin
        entry_used_next   = entry_used_reg;
        entry_locked_next = entry_locked_reg;
        key_we            = 1'b0;
        key_waddr         = match.free_idx;
        res_handle_next   = 4'd0;
        res_status_next   = STAT_INVALID;
        case (req_mode_reg)
            MODE_CREATE: begin
                if (match.found) begin
                    res_status_next = STAT_DUPLICATE;
                end else if (!match.free_found) begin
                    res_status_next = STAT_FULL;
                end else begin
                    entry_used_next[match.free_idx]   = 1'b1;
                    entry_locked_next[match.free_idx] = 1'b0;
                    key_we          = (state_reg == ST_EXEC) && out_free;
                    res_handle_next = 4'(match.free_idx);
                    res_status_next = STAT_OK;
                end
            end
            MODE_LOOKUP: begin
                if (match.found) begin
                    res_handle_next = 4'(match.found_idx);
                    res_status_next = STAT_OK;
                end else begin
                    res_status_next = STAT_NOT_FOUND;
                end
            end
            MODE_DESTROY: begin
                if (32'(req_handle_reg) >= 32'(TABLE_ENTRIES)) begin
                    res_status_next = STAT_INVALID;
                end else if (!entry_used_reg[hnd_idx]) begin
                    res_status_next = STAT_NOT_FOUND;
                end else if (entry_locked_reg[hnd_idx]) begin
                    res_status_next = STAT_RETRY;
                end else begin
                    // key left stale: unused entries never match
                    entry_used_next[hnd_idx]   = 1'b0;
                    entry_locked_next[hnd_idx] = 1'b0;
                    res_status_next = STAT_OK;
                end
            end
            MODE_LOCK: begin
                if (!match.found) begin
                    res_status_next = STAT_NOT_FOUND;
                end else begin
                    res_handle_next = 4'(match.found_idx);
                    if (entry_locked_reg[match.found_idx]) begin
                        res_status_next = STAT_RETRY;
                    end else begin
                        entry_locked_next[match.found_idx] = 1'b1;
                        res_status_next = STAT_OK;
                    end
                end
            end
            MODE_UNLOCK: begin
                if (!match.found) begin
                    res_status_next = STAT_NOT_FOUND;
                end else begin
                    res_handle_next = 4'(match.found_idx);
                    if (!entry_locked_reg[match.found_idx]) begin
                        res_status_next = STAT_RETRY;
                    end else begin
                        entry_locked_next[match.found_idx] = 1'b0;
                        res_status_next = STAT_OK;
                    end
                end
            end
            default: begin
                res_status_next = STAT_INVALID;
            end
        endcase
    end

    // sequencer, marks and answer register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            entry_used_reg   <= '0;
            entry_locked_reg <= '0;
            cnt_reg          <= '0;
            cmp_valid_reg    <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    cmp_valid_reg <= 1'b0;
                    cnt_reg       <= '0;
                    if (start) begin
                        req_mode_reg   <= s_tuser;
                        req_key_reg    <= s_tdata[31:0];
                        req_handle_reg <= s_tdata[35:32];
                        // only keyed operations walk the store
                        if (s_tuser == MODE_DESTROY || s_tuser > MODE_UNLOCK) begin
                            state_reg <= ST_EXEC;
                        end else begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (hit_now || scan_last) begin
                        cmp_valid_reg <= 1'b0;
                        state_reg     <= ST_EXEC;
                    end else begin
                        cmp_valid_reg <= rd_en;
                        cmp_idx_reg   <= cnt_reg[IDX_W-1:0];
                        if (rd_en) begin
                            cnt_reg <= cnt_reg + CNT_W'(1);
                        end
                    end
                end
                ST_EXEC: begin
                    // hold until the previous answer has been taken
                    if (out_free) begin
                        entry_used_reg   <= entry_used_next;
                        entry_locked_reg <= entry_locked_next;
                        res_handle_reg   <= res_handle_next;
                        res_status_reg   <= res_status_next;
                        m_tvalid_reg     <= 1'b1;
                        state_reg        <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, res_status_reg, res_handle_reg};

endmodule

// ===== rtl/core/klt_checker.sv =====
// ----------------------------------------------------------------------------
// klt_checker
// port-level checks for the keyed lock table, bound to the top level
// ----------------------------------------------------------------------------
module klt_checker
    import klt_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    // stalled answer stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("answer dropped while stalled");

    // one request in work at a time
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // status stays within the defined codes
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[6:4] <= STAT_INVALID) && !m_tdata[7])
        else $error("undefined status code");

    // failures without an entry report handle zero
    a_fail_handle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[6:4] == STAT_NOT_FOUND || m_tdata[6:4] == STAT_DUPLICATE ||
                     m_tdata[6:4] == STAT_FULL || m_tdata[6:4] == STAT_INVALID)
        |-> (m_tdata[3:0] == 4'd0))
        else $error("nonzero handle on failed request");

endmodule

bind keyed_lock_table_top klt_checker u_klt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
